// ===== src/z_buffer_depth_test_assert.svh =====
// Assertion macros used by the checker file.
`ifndef Z_BUFFER_DEPTH_TEST_ASSERT_SVH
`define Z_BUFFER_DEPTH_TEST_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define ZBDT_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("zbdt assertion failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define ZBDT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("zbdt assertion failed");

`endif

// ===== src/zbdt_pkg.sv =====
package zbdt_pkg;

  localparam int CMD_W       = 2;
  localparam int COORD_W     = 8;
  localparam int DEPTH_W     = 16;
  localparam int COLOR_W     = 8;
  localparam int STORE_DEPTH = 65536;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int DEF_WIDTH   = 256;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [DEPTH_W-1:0] FAR_DEPTH = '1;
  localparam logic [COLOR_W-1:0] CLEAR_COLOR = '0;

  localparam logic [CMD_W-1:0] CMD_FRAG  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

  typedef enum logic [1:0] {
    OP_FRAG,
    OP_READ,
    OP_CLEAR,
    OP_SKIP
  } op_t;

  typedef struct packed {
    logic [COLOR_W-1:0] color;
    logic [DEPTH_W-1:0] depth;
  } pixel_t;

  typedef struct packed {
    op_t                op;
    logic [ADDR_W-1:0]  addr;
    logic [DEPTH_W-1:0] depth;
    logic [COLOR_W-1:0] color;
  } q_entry_t;

  typedef struct packed {
    logic     push;
    q_entry_t entry;
  } q_wr_t;

  typedef struct packed {
    logic     valid;
    q_entry_t entry;
  } q_rd_t;

  typedef struct packed {
    logic clearing;
    logic q_full;
  } front_ctl_t;

  typedef enum logic [1:0] {
    BS_CLEAR,
    BS_IDLE,
    BS_READ,
    BS_EXEC
  } back_state_t;

endpackage

// ===== src/zbdt_ram.sv =====
module zbdt_ram #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 16,
  parameter int AW     = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [AW-1:0]     wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic [AW-1:0]     rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem_r [DEPTH];
  logic [DATA_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== src/zbdt_front.sv =====
module zbdt_front #(
  parameter int WIDTH = zbdt_pkg::DEF_WIDTH
) (
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [zbdt_pkg::CMD_W-1:0]   in_cmd,
  input  logic [zbdt_pkg::COORD_W-1:0] in_pixel_row,
  input  logic [zbdt_pkg::COORD_W-1:0] in_pixel_col,
  input  logic [zbdt_pkg::DEPTH_W-1:0] in_frag_depth,
  input  logic [zbdt_pkg::COLOR_W-1:0] in_frag_color,
  input  zbdt_pkg::front_ctl_t         ctl,
  output zbdt_pkg::q_wr_t              q_wr
);

  localparam int WW = $clog2(WIDTH + 1);
  localparam int PW = zbdt_pkg::COORD_W + WW + 1;
  localparam int SW = $clog2(zbdt_pkg::STORE_DEPTH + 1);
  localparam int LW = (PW > SW) ? PW : SW;

  logic [LW-1:0] row_x;
  logic [LW-1:0] col_x;
  logic [LW-1:0] width_x;
  logic [LW-1:0] lin;
  logic          in_range;
  zbdt_pkg::op_t op;

  assign row_x   = LW'(in_pixel_row);
  assign col_x   = LW'(in_pixel_col);
  assign width_x = LW'(WIDTH);
  assign lin     = row_x * width_x + col_x;

  assign in_range = (row_x < width_x) && (col_x < width_x) &&
                    (lin < LW'(zbdt_pkg::STORE_DEPTH));

  // Out-of-buffer coordinates become a no-op that reports an empty pixel.
  always_comb begin
    if (!in_range) begin
      op = zbdt_pkg::OP_SKIP;
    end else begin
      case (in_cmd)
        zbdt_pkg::CMD_FRAG:  op = zbdt_pkg::OP_FRAG;
        zbdt_pkg::CMD_CLEAR: op = zbdt_pkg::OP_CLEAR;
        default:             op = zbdt_pkg::OP_READ;
      endcase
    end
  end

  assign in_stall          = ctl.q_full || ctl.clearing;
  assign q_wr.push         = in_valid && !in_stall;
  assign q_wr.entry.op     = op;
  assign q_wr.entry.addr   = lin[zbdt_pkg::ADDR_W-1:0];
  assign q_wr.entry.depth  = in_frag_depth;
  assign q_wr.entry.color  = in_frag_color;

endmodule

// ===== src/zbdt_queue.sv =====
module zbdt_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  zbdt_pkg::q_wr_t q_wr,
  input  logic            pop,
  output zbdt_pkg::q_rd_t q_rd,
  output logic            full
);

  localparam int DEPTH = zbdt_pkg::QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  zbdt_pkg::q_entry_t slot_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               do_pop;

  assign do_pop = pop && (count_r != '0);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (q_wr.push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (q_wr.push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !q_wr.push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_wr.push) begin
      slot_r[wr_ptr_r] <= q_wr.entry;
    end
  end

  assign q_rd.valid = (count_r != '0);
  assign q_rd.entry = slot_r[rd_ptr_r];
  assign full       = (count_r == CNT_W'(DEPTH));

endmodule

// ===== src/zbdt_back.sv =====
module zbdt_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  zbdt_pkg::q_rd_t              q_rd,
  output logic                         pop,
  output logic                         clearing,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         out_was_written,
  output logic [zbdt_pkg::COLOR_W-1:0] out_color,
  output logic [zbdt_pkg::DEPTH_W-1:0] out_depth
);

  zbdt_pkg::back_state_t state_r, state_nxt;
  zbdt_pkg::q_entry_t    cur_r, cur_nxt;
  logic [zbdt_pkg::ADDR_W-1:0] clr_cnt_r, clr_cnt_nxt;

  logic                 out_valid_r, out_valid_nxt;
  logic                 out_wr_r, out_wr_nxt;
  zbdt_pkg::pixel_t     out_pix_r, out_pix_nxt;

  logic                        ram_wr_en;
  logic [zbdt_pkg::ADDR_W-1:0] ram_wr_addr;
  zbdt_pkg::pixel_t            ram_wr_data;
  zbdt_pkg::pixel_t            ram_rd_data;

  zbdt_pkg::pixel_t empty_pix;
  zbdt_pkg::pixel_t frag_pix;
  zbdt_pkg::pixel_t res_pix;
  logic             res_wr;
  logic             do_write;
  logic             out_free;

  assign empty_pix.color = zbdt_pkg::CLEAR_COLOR;
  assign empty_pix.depth = zbdt_pkg::FAR_DEPTH;
  assign frag_pix.color  = cur_r.color;
  assign frag_pix.depth  = cur_r.depth;
  assign out_free        = !out_valid_r || !out_stall;

  zbdt_ram #(
    .DATA_W ($bits(zbdt_pkg::pixel_t)),
    .DEPTH  (zbdt_pkg::STORE_DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_addr (cur_r.addr),
    .rd_data (ram_rd_data)
  );

  // Resolve the transaction against the stored pixel.
  always_comb begin
    res_wr   = 1'b0;
    do_write = 1'b0;
    res_pix  = ram_rd_data;
    case (cur_r.op)
      zbdt_pkg::OP_FRAG: begin
        if (cur_r.depth < ram_rd_data.depth) begin
          res_wr   = 1'b1;
          do_write = 1'b1;
          res_pix  = frag_pix;
        end
      end
      zbdt_pkg::OP_CLEAR: begin
        res_wr   = 1'b1;
        do_write = 1'b1;
        res_pix  = empty_pix;
      end
      zbdt_pkg::OP_SKIP: begin
        res_pix = empty_pix;
      end
      default: begin
        res_pix = ram_rd_data;
      end
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    cur_nxt       = cur_r;
    clr_cnt_nxt   = clr_cnt_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_wr_nxt    = out_wr_r;
    out_pix_nxt   = out_pix_r;
    pop           = 1'b0;
    ram_wr_en     = 1'b0;
    ram_wr_addr   = cur_r.addr;
    ram_wr_data   = res_pix;
    case (state_r)
      zbdt_pkg::BS_CLEAR: begin
        ram_wr_en   = 1'b1;
        ram_wr_addr = clr_cnt_r;
        ram_wr_data = empty_pix;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == '1) begin
          state_nxt = zbdt_pkg::BS_IDLE;
        end
      end
      zbdt_pkg::BS_IDLE: begin
        if (q_rd.valid) begin
          pop       = 1'b1;
          cur_nxt   = q_rd.entry;
          state_nxt = zbdt_pkg::BS_READ;
        end
      end
      zbdt_pkg::BS_READ: begin
        state_nxt = zbdt_pkg::BS_EXEC;
      end
      zbdt_pkg::BS_EXEC: begin
        // Hold the read data until the result register frees up.
        if (out_free) begin
          ram_wr_en     = do_write;
          out_valid_nxt = 1'b1;
          out_wr_nxt    = res_wr;
          out_pix_nxt   = res_pix;
          state_nxt     = zbdt_pkg::BS_IDLE;
        end
      end
      default: begin
        state_nxt = zbdt_pkg::BS_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= zbdt_pkg::BS_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r     <= cur_nxt;
    out_wr_r  <= out_wr_nxt;
    out_pix_r <= out_pix_nxt;
  end

  assign clearing        = (state_r == zbdt_pkg::BS_CLEAR);
  assign out_valid       = out_valid_r;
  assign out_was_written = out_wr_r;
  assign out_color       = out_pix_r.color;
  assign out_depth       = out_pix_r.depth;

endmodule

// ===== src/z_buffer_depth_test.sv =====
// Depth-tested pixel store of WIDTH x WIDTH pixels (at most 65536), each an 8-bit color and
// a 16-bit depth at address row*WIDTH+column. Every transaction returns one result: a
// fragment is written only when its depth is strictly below the stored one, a read returns
// the pixel, a clear sets it to color 0 and far depth; off-buffer coordinates change nothing
// and report an empty pixel. After reset the store is swept to its empty value, one pixel a
// cycle over all 65536 addresses, while in_stall stays high. Accepted transactions pass
// through a two-entry queue; the back end then takes each in three steps (dequeue, RAM
// read, test and write-back into the result register) and finishes one before it dequeues
// the next, as set by the read-modify-write on the single pixel RAM. A waiting result does
// not block intake until the queue is full.
module z_buffer_depth_test #(
  parameter int WIDTH = zbdt_pkg::DEF_WIDTH
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [zbdt_pkg::CMD_W-1:0]   in_cmd,
  input  logic [zbdt_pkg::COORD_W-1:0] in_pixel_row,
  input  logic [zbdt_pkg::COORD_W-1:0] in_pixel_col,
  input  logic [zbdt_pkg::DEPTH_W-1:0] in_frag_depth,
  input  logic [zbdt_pkg::COLOR_W-1:0] in_frag_color,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         out_was_written,
  output logic [zbdt_pkg::COLOR_W-1:0] out_color,
  output logic [zbdt_pkg::DEPTH_W-1:0] out_depth
);

  zbdt_pkg::q_wr_t      q_wr;
  zbdt_pkg::q_rd_t      q_rd;
  zbdt_pkg::front_ctl_t ctl;
  logic                 q_full;
  logic                 clearing;
  logic                 pop;

  assign ctl.q_full   = q_full;
  assign ctl.clearing = clearing;

  zbdt_front #(
    .WIDTH (WIDTH)
  ) u_front (
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_cmd        (in_cmd),
    .in_pixel_row  (in_pixel_row),
    .in_pixel_col  (in_pixel_col),
    .in_frag_depth (in_frag_depth),
    .in_frag_color (in_frag_color),
    .ctl           (ctl),
    .q_wr          (q_wr)
  );

  zbdt_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .q_wr  (q_wr),
    .pop   (pop),
    .q_rd  (q_rd),
    .full  (q_full)
  );

  zbdt_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_rd            (q_rd),
    .pop             (pop),
    .clearing        (clearing),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_was_written (out_was_written),
    .out_color       (out_color),
    .out_depth       (out_depth)
  );

endmodule

// ===== src/zbdt_checker.sv =====
`include "z_buffer_depth_test_assert.svh"

module zbdt_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_stall,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic                         out_was_written,
  input logic [zbdt_pkg::COLOR_W-1:0] out_color,
  input logic [zbdt_pkg::DEPTH_W-1:0] out_depth
);

  // A stalled result must hold.
  `ZBDT_ASSERT_NEXT(a_out_hold,
                    out_valid && out_stall,
                    out_valid && $stable(out_was_written) && $stable(out_color) &&
                    $stable(out_depth))

  // A written far depth can only come from a clear, so its color is empty.
  `ZBDT_ASSERT_NOW(a_far_write_is_clear,
                   out_valid && out_was_written && (out_depth == zbdt_pkg::FAR_DEPTH),
                   out_color == zbdt_pkg::CLEAR_COLOR)

  // Right after reset the store sweep is running: no intake, no result.
  `ZBDT_ASSERT_NOW(a_reset_sweep, !$past(rst_n), in_stall && !out_valid)

endmodule

bind z_buffer_depth_test zbdt_checker u_zbdt_checker (.*);
